// File: design/efcu_pkg.sv
package efcu_pkg;

    localparam int VECTOR_FRAC_BITS = 14;
    localparam int POSITION_WIDTH   = 32;

    typedef enum logic [1:0] {
        OP_ROTATE  = 2'd0,
        OP_MOVE    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam logic [2:0] DIR_FORWARD  = 3'd0;
    localparam logic [2:0] DIR_BACKWARD = 3'd1;
    localparam logic [2:0] DIR_LEFT     = 3'd2;
    localparam logic [2:0] DIR_RIGHT    = 3'd3;
    localparam logic [2:0] DIR_UP       = 3'd4;
    localparam logic [2:0] DIR_DOWN     = 3'd5;

    localparam logic [1:0] REG_START_X    = 2'd0;
    localparam logic [1:0] REG_START_Y    = 2'd1;
    localparam logic [1:0] REG_START_Z    = 2'd2;
    localparam logic [1:0] REG_MOVE_SPEED = 2'd3;

    localparam logic [15:0] MOVE_SPEED_RESET = 16'd640;

    // angles in Q8 degrees
    localparam logic [16:0] DEG45  = 17'd11520;
    localparam logic [16:0] DEG89  = 17'd22784;
    localparam logic [16:0] DEG90  = 17'd23040;
    localparam logic [16:0] DEG180 = 17'd46080;
    localparam logic [17:0] DEG360 = 18'd92160;

    localparam logic [22:0] DEG_TO_RAD = 23'd4685083;
    localparam logic [28:0] Q28_ONE    = 29'h1000_0000;

    typedef enum logic [4:0] {
        U_ENTRY, U_RAD, U_SQR, U_DIV, U_XT, U_RT, U_HALF, U_STORE,
        U_B0, U_B2, U_B6, U_B8, U_BSINGLE, U_VEL, U_MV0, U_MV1, U_MV2
    } uop_t;

    typedef enum logic [2:0] {D42, D20, D6, D56, D30, D12} div_t;

    typedef enum logic [2:0] {
        ST_BOOT, ST_IDLE, ST_DISPATCH, ST_ISSUE, ST_WB, ST_DONE
    } state_t;

    typedef struct packed {
        uop_t uop;
        logic pitch_sel;
        div_t dv;
        logic last;
    } uentry_t;

    typedef struct packed {
        logic boot;
        logic load;
        logic issue;
        logic wb;
        logic out_load;
        uop_t uop;
        logic pitch_sel;
        div_t dv;
    } cmd_t;

    typedef struct packed {
        op_t op;
    } stat_t;

    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PC_ENTRY = 6'd0;
    localparam logic [PC_W-1:0] PC_MOVE  = 6'd38;

    function automatic logic [31:0] recip(input div_t d);
        logic [31:0] v;
        case (d)
            D42:     v = 32'd102261126;
            D20:     v = 32'd214748364;
            D6:      v = 32'd715827882;
            D56:     v = 32'd76695844;
            D30:     v = 32'd143165576;
            D12:     v = 32'd357913941;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] divisor(input div_t d);
        logic [5:0] v;
        case (d)
            D42:     v = 6'd42;
            D20:     v = 6'd20;
            D6:      v = 6'd6;
            D56:     v = 6'd56;
            D30:     v = 6'd30;
            D12:     v = 6'd12;
            default: v = 6'd1;
        endcase
        return v;
    endfunction

    // microprogram: entry, yaw trig, pitch trig, basis, then move
    function automatic uentry_t prog(input logic [PC_W-1:0] pc);
        uentry_t e;
        logic [4:0] k;
        e = '{uop: U_ENTRY, pitch_sel: 1'b0, dv: D42, last: 1'b0};
        if (pc >= 6'd1 && pc <= 6'd32) begin
            e.pitch_sel = (pc >= 6'd17);
            k = e.pitch_sel ? 5'(pc - 6'd17) : 5'(pc - 6'd1);
            case (k)
                5'd0:    e.uop = U_RAD;
                5'd1:    e.uop = U_SQR;
                5'd2:    begin e.uop = U_DIV; e.dv = D42; end
                5'd3:    e.uop = U_XT;
                5'd4:    begin e.uop = U_DIV; e.dv = D20; end
                5'd5:    e.uop = U_XT;
                5'd6:    begin e.uop = U_DIV; e.dv = D6; end
                5'd7:    e.uop = U_RT;
                5'd8:    begin e.uop = U_DIV; e.dv = D56; end
                5'd9:    e.uop = U_XT;
                5'd10:   begin e.uop = U_DIV; e.dv = D30; end
                5'd11:   e.uop = U_XT;
                5'd12:   begin e.uop = U_DIV; e.dv = D12; end
                5'd13:   e.uop = U_XT;
                5'd14:   e.uop = U_HALF;
                default: e.uop = U_STORE;
            endcase
        end else begin
            case (pc)
                6'd33:   e.uop = U_B0;
                6'd34:   e.uop = U_B2;
                6'd35:   e.uop = U_B6;
                6'd36:   e.uop = U_B8;
                6'd37:   begin e.uop = U_BSINGLE; e.last = 1'b1; end
                6'd38:   e.uop = U_VEL;
                6'd39:   e.uop = U_MV0;
                6'd40:   e.uop = U_MV1;
                6'd41:   begin e.uop = U_MV2; e.last = 1'b1; end
                default: e.uop = U_ENTRY;
            endcase
        end
        return e;
    endfunction

endpackage

// File: design/euler_fly_camera_update.sv
// Free-look camera state engine.
// Input items arrive on the s_ stream: s_tuser carries the operation
// (rotate, move, restart), s_tdata carries offsets, direction and time step.
// Every item gives one result item on the m_ stream with the position and
// the front, right and up vectors after the update.
// Start position and move speed are set over the APB port; write them only
// while the block is idle.
// Items are handled one at a time by a microcoded sequencer driving one
// shared multiplier; each micro-step has an issue state and a write-back
// state. A rotate or restart runs two sine/cosine evaluations plus four
// basis products before its result is put out. The next item can be
// accepted in the cycle after the result is loaded.
// The result sits in an output register; a new item is accepted while it
// waits, and the next result is held back until m_tready takes the old one.
// After reset the block runs the restart sequence with s_tready low, then
// waits for items with m_tvalid low.
module euler_fly_camera_update #(
    parameter int VECTOR_FRAC_BITS = efcu_pkg::VECTOR_FRAC_BITS,
    parameter int POSITION_WIDTH   = efcu_pkg::POSITION_WIDTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // yaw_offset, pitch_offset, move_direction, time_step
    input  logic [55:0]  s_tdata,
    // operation
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, pos_z, front_x, front_y, front_z,
    // right_x, right_y, right_z, up_x, up_y, up_z
    output logic [239:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import efcu_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic signed [31:0] start_x, start_y, start_z;
    logic [15:0] move_speed;

    efcu_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start_x    (start_x),
        .start_y    (start_y),
        .start_z    (start_z),
        .move_speed (move_speed)
    );

    efcu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    efcu_dp #(
        .VECTOR_FRAC_BITS (VECTOR_FRAC_BITS),
        .POSITION_WIDTH   (POSITION_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .cmd        (cmd),
        .stat       (stat),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .start_x    (start_x),
        .start_y    (start_y),
        .start_z    (start_z),
        .move_speed (move_speed),
        .m_tdata    (m_tdata)
    );

endmodule

// File: design/efcu_cfg.sv
module efcu_cfg (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic signed [31:0] start_x,
    output logic signed [31:0] start_y,
    output logic signed [31:0] start_z,
    output logic [15:0] move_speed
);
    import efcu_pkg::*;

    logic signed [31:0] start_x_reg, start_y_reg, start_z_reg;
    logic [15:0] move_speed_reg;
    logic wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            start_z_reg    <= '0;
            move_speed_reg <= MOVE_SPEED_RESET;
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_START_X:    start_x_reg    <= pwdata;
                REG_START_Y:    start_y_reg    <= pwdata;
                REG_START_Z:    start_z_reg    <= pwdata;
                REG_MOVE_SPEED: move_speed_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_START_X:    prdata = start_x_reg;
            REG_START_Y:    prdata = start_y_reg;
            REG_START_Z:    prdata = start_z_reg;
            REG_MOVE_SPEED: prdata = {16'd0, move_speed_reg};
            default:        prdata = '0;
        endcase
    end

    assign start_x    = start_x_reg;
    assign start_y    = start_y_reg;
    assign start_z    = start_z_reg;
    assign move_speed = move_speed_reg;

endmodule

// File: design/efcu_ctrl.sv
module efcu_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  efcu_pkg::stat_t stat,
    output efcu_pkg::cmd_t  cmd
);
    import efcu_pkg::*;

    state_t state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic boot_reg, boot_next;
    logic m_valid_reg, m_valid_next;
    uentry_t entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_BOOT;
            pc_reg      <= '0;
            boot_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            boot_reg    <= boot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        entry        = prog(pc_reg);
        state_next   = state_reg;
        pc_next      = pc_reg;
        boot_next    = boot_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.uop       = entry.uop;
        cmd.pitch_sel = entry.pitch_sel;
        cmd.dv        = entry.dv;
        unique case (state_reg)
            ST_BOOT: begin
                cmd.boot   = 1'b1;
                boot_next  = 1'b1;
                state_next = ST_DISPATCH;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (stat.op) inside
                    OP_ROTATE, OP_RESTART: begin
                        pc_next    = PC_ENTRY;
                        state_next = ST_ISSUE;
                    end
                    OP_MOVE: begin
                        pc_next    = PC_MOVE;
                        state_next = ST_ISSUE;
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_ISSUE: begin
                cmd.issue  = 1'b1;
                state_next = ST_WB;
            end
            ST_WB: begin
                cmd.wb = 1'b1;
                if (entry.last) begin
                    state_next = boot_reg ? ST_IDLE : ST_DONE;
                    boot_next  = 1'b0;
                end else begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_BOOT;
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

// File: design/efcu_dp.sv
module efcu_dp #(
    parameter int VECTOR_FRAC_BITS = efcu_pkg::VECTOR_FRAC_BITS,
    parameter int POSITION_WIDTH   = efcu_pkg::POSITION_WIDTH
) (
    input  logic                aclk,
    input  efcu_pkg::cmd_t      cmd,
    output efcu_pkg::stat_t     stat,
    input  logic [55:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic signed [31:0]  start_x,
    input  logic signed [31:0]  start_y,
    input  logic signed [31:0]  start_z,
    input  logic [15:0]         move_speed,
    output logic [239:0]        m_tdata
);
    import efcu_pkg::*;

    localparam int VEC_W = VECTOR_FRAC_BITS + 2;
    localparam int PW    = POSITION_WIDTH;
    localparam int EW    = (PW > 32 ? PW : 32) + 1;
    localparam int S1    = 28 - VECTOR_FRAC_BITS;
    localparam int S2    = 56 - VECTOR_FRAC_BITS;
    localparam int SM    = VECTOR_FRAC_BITS + 8;
    localparam logic signed [EW-1:0] POS_HI = {{(EW-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic signed [EW-1:0] POS_LO = ~POS_HI;

    function automatic logic signed [VEC_W-1:0] rnd28(input logic signed [29:0] v);
        logic [29:0] mag;
        logic [29:0] r;
        logic signed [VEC_W-1:0] rv;
        mag = v[29] ? 30'(-v) : 30'(v);
        r   = (mag + (30'd1 << (S1 - 1))) >> S1;
        rv  = VEC_W'(r);
        return v[29] ? -rv : rv;
    endfunction

    function automatic logic signed [VEC_W-1:0] rnd56(input logic signed [65:0] v);
        logic [65:0] mag;
        logic [65:0] r;
        logic signed [VEC_W-1:0] rv;
        mag = v[65] ? 66'(-v) : 66'(v);
        r   = (mag + (66'd1 << (S2 - 1))) >> S2;
        rv  = VEC_W'(r);
        return v[65] ? -rv : rv;
    endfunction

    function automatic logic signed [EW-1:0] rndmv(input logic signed [65:0] v);
        logic [65:0] mag;
        logic [65:0] r;
        logic signed [EW-1:0] rv;
        mag = v[65] ? 66'(-v) : 66'(v);
        r   = (mag + (66'd1 << (SM - 1))) >> SM;
        rv  = EW'(r);
        return v[65] ? -rv : rv;
    endfunction

    function automatic logic signed [PW-1:0] sat(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] c;
        if (v > POS_HI)      c = POS_HI;
        else if (v < POS_LO) c = POS_LO;
        else                 c = v;
        return PW'(c);
    endfunction

    op_t                op_reg;
    logic signed [15:0] yaw_off_reg, pitch_off_reg;
    logic [2:0]         dir_reg;
    logic [15:0]        ts_reg;
    logic signed [16:0] yaw_reg;
    logic signed [15:0] pitch_reg;
    logic signed [PW-1:0]    pos_reg [3];
    logic signed [VEC_W-1:0] basis_reg [9];
    logic [27:0] r_reg, x2_reg, w_reg, s_oct_reg;
    logic [28:0] t_reg, c_oct_reg;
    logic sneg_reg, cneg_reg, swap_reg;
    logic signed [29:0] sy_reg, cy_reg, sp_reg, cp_reg;
    logic [31:0] vel_reg;
    logic signed [65:0] prod_reg;
    logic [239:0] m_tdata_reg;

    // angle folding
    logic signed [16:0] ang;
    logic [16:0] amag, afold, red_m;
    logic red_sneg, red_cneg, red_swap;

    always_comb begin
        ang      = cmd.pitch_sel ? 17'(pitch_reg) : yaw_reg;
        red_sneg = ang[16];
        amag     = red_sneg ? 17'(-ang) : 17'(ang);
        if (amag > DEG180) amag = DEG180;
        red_cneg = (amag > DEG90);
        afold    = red_cneg ? DEG180 - amag : amag;
        red_swap = (afold > DEG45);
        red_m    = red_swap ? DEG90 - afold : afold;
    end

    // move direction decode
    logic [3:0] mv_idx;
    logic [1:0] mv_base, mv_i;
    logic mv_neg, mv_ok;

    always_comb begin
        case (dir_reg) inside
            DIR_FORWARD, DIR_BACKWARD: mv_base = 2'd0;
            DIR_LEFT, DIR_RIGHT:       mv_base = 2'd1;
            DIR_UP, DIR_DOWN:          mv_base = 2'd2;
            default:                   mv_base = 2'd0;
        endcase
        mv_neg = (dir_reg == DIR_BACKWARD) || (dir_reg == DIR_LEFT) || (dir_reg == DIR_DOWN);
        mv_ok  = (dir_reg <= DIR_DOWN);
        case (cmd.uop)
            U_MV1:   mv_i = 2'd1;
            U_MV2:   mv_i = 2'd2;
            default: mv_i = 2'd0;
        endcase
        mv_idx = 4'(mv_base) * 4'd3 + 4'(mv_i);
    end

    // shared multiplier operands
    logic [27:0] div_src;
    logic signed [32:0] mul_a, mul_b;

    assign div_src = (cmd.dv == D42 || cmd.dv == D56) ? x2_reg : w_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.uop)
            U_RAD: begin mul_a = $signed(33'(red_m));  mul_b = $signed(33'(DEG_TO_RAD)); end
            U_SQR: begin mul_a = $signed(33'(r_reg));  mul_b = $signed(33'(r_reg)); end
            U_DIV: begin
                mul_a = $signed(33'(div_src));
                mul_b = $signed(33'(recip(cmd.dv)));
            end
            U_XT:  begin mul_a = $signed(33'(x2_reg)); mul_b = $signed(33'(t_reg)); end
            U_RT:  begin mul_a = $signed(33'(r_reg));  mul_b = $signed(33'(t_reg)); end
            U_B0:  begin mul_a = 33'(cy_reg); mul_b = 33'(cp_reg); end
            U_B2:  begin mul_a = 33'(sy_reg); mul_b = 33'(cp_reg); end
            U_B6:  begin mul_a = 33'(cy_reg); mul_b = 33'(sp_reg); end
            U_B8:  begin mul_a = 33'(sy_reg); mul_b = 33'(sp_reg); end
            U_VEL: begin
                mul_a = $signed(33'(move_speed));
                mul_b = $signed(33'(ts_reg));
            end
            U_MV0, U_MV1, U_MV2: begin
                mul_a = 33'(basis_reg[mv_idx]);
                mul_b = $signed(33'(vel_reg));
            end
            default: ;
        endcase
    end

    // division correction
    logic [27:0] q0, q;
    logic [33:0] qn, rem;
    logic [28:0] t_next;

    always_comb begin
        q0     = prod_reg[59:32];
        qn     = 34'(q0) * 34'(divisor(cmd.dv));
        rem    = 34'(div_src) - qn;
        q      = (rem >= 34'(divisor(cmd.dv))) ? q0 + 28'd1 : q0;
        t_next = Q28_ONE - 29'(q);
    end

    // angle update
    logic signed [17:0] yaw_sum;
    logic signed [16:0] pitch_sum;
    logic signed [16:0] yaw_next;
    logic signed [15:0] pitch_next;

    always_comb begin
        yaw_sum = 18'(yaw_reg) + 18'(yaw_off_reg);
        if (yaw_sum >= $signed({1'b0, DEG180}))       yaw_sum = yaw_sum - $signed(DEG360);
        else if (yaw_sum < -$signed({1'b0, DEG180}))  yaw_sum = yaw_sum + $signed(DEG360);
        yaw_next  = 17'(yaw_sum);
        pitch_sum = 17'(pitch_reg) + 17'(pitch_off_reg);
        if (pitch_sum > $signed(DEG89))       pitch_sum = $signed(DEG89);
        else if (pitch_sum < -$signed(DEG89)) pitch_sum = -$signed(DEG89);
        pitch_next = 16'(pitch_sum);
    end

    // sign fix of octant results
    logic [28:0] sv, cv;
    logic signed [29:0] s_next, c_next;

    always_comb begin
        sv     = swap_reg ? c_oct_reg : 29'(s_oct_reg);
        cv     = swap_reg ? 29'(s_oct_reg) : c_oct_reg;
        s_next = sneg_reg ? -$signed(30'(sv)) : $signed(30'(sv));
        c_next = cneg_reg ? -$signed(30'(cv)) : $signed(30'(cv));
    end

    // position update
    logic signed [EW-1:0] mv_d, mv_cur, mv_new;

    always_comb begin
        mv_d   = rndmv(prod_reg);
        mv_cur = EW'(pos_reg[mv_i]);
        mv_new = mv_neg ? mv_cur - mv_d : mv_cur + mv_d;
    end

    always_ff @(posedge aclk) begin
        if (cmd.boot) op_reg <= OP_RESTART;
        if (cmd.load) begin
            op_reg        <= op_t'(s_tuser);
            yaw_off_reg   <= s_tdata[15:0];
            pitch_off_reg <= s_tdata[31:16];
            dir_reg       <= s_tdata[34:32];
            ts_reg        <= s_tdata[50:35];
        end
        if (cmd.issue) prod_reg <= mul_a * mul_b;
        if (cmd.wb) begin
            unique case (cmd.uop)
                U_ENTRY: begin
                    if (op_reg == OP_ROTATE) begin
                        yaw_reg   <= yaw_next;
                        pitch_reg <= pitch_next;
                    end else begin
                        yaw_reg    <= -$signed(DEG89);
                        pitch_reg  <= '0;
                        pos_reg[0] <= sat(EW'(start_x));
                        pos_reg[1] <= sat(EW'(start_y));
                        pos_reg[2] <= sat(EW'(start_z));
                    end
                end
                U_RAD: begin
                    r_reg    <= prod_reg[35:8];
                    sneg_reg <= red_sneg;
                    cneg_reg <= red_cneg;
                    swap_reg <= red_swap;
                end
                U_SQR:  x2_reg    <= prod_reg[55:28];
                U_DIV:  t_reg     <= t_next;
                U_XT:   w_reg     <= prod_reg[55:28];
                U_RT:   s_oct_reg <= prod_reg[55:28];
                U_HALF: c_oct_reg <= Q28_ONE - 29'(w_reg >> 1);
                U_STORE: begin
                    if (cmd.pitch_sel) begin
                        sp_reg <= s_next;
                        cp_reg <= c_next;
                    end else begin
                        sy_reg <= s_next;
                        cy_reg <= c_next;
                    end
                end
                U_B0: basis_reg[0] <= rnd56(prod_reg);
                U_B2: basis_reg[2] <= rnd56(prod_reg);
                U_B6: basis_reg[6] <= -rnd56(prod_reg);
                U_B8: basis_reg[8] <= -rnd56(prod_reg);
                U_BSINGLE: begin
                    basis_reg[1] <= rnd28(sp_reg);
                    basis_reg[3] <= -rnd28(sy_reg);
                    basis_reg[4] <= '0;
                    basis_reg[5] <= rnd28(cy_reg);
                    basis_reg[7] <= rnd28(cp_reg);
                end
                U_VEL: vel_reg <= prod_reg[31:0];
                U_MV0, U_MV1, U_MV2: begin
                    if (mv_ok) pos_reg[mv_i] <= sat(mv_new);
                end
                default: ;
            endcase
        end
        if (cmd.out_load) begin
            for (int i = 0; i < 3; i++) begin
                m_tdata_reg[32*i +: 32] <= 32'(EW'(pos_reg[i]));
            end
            for (int j = 0; j < 9; j++) begin
                m_tdata_reg[96 + 16*j +: 16] <= 16'(32'(basis_reg[j]));
            end
        end
    end

    assign stat.op = op_reg;
    assign m_tdata = m_tdata_reg;

endmodule

// File: sim/efcu_checker.sv
`timescale 1ns / 100ps

module efcu_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [55:0]  s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [239:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           results_pending
);
    import efcu_pkg::*;

    localparam longint unsigned ONE_Q28 = 64'd1 << 28;
    localparam int YAW_REST = -22784;
    localparam int PITCH_LIMIT = 22784;
    localparam int HALF_TURN = 46080;
    localparam int FULL_TURN = 92160;

    longint start_pos [3];
    logic [15:0] speed;
    int yaw, pitch;
    longint cam_pos [3];
    logic signed [15:0] basis [9];
    logic [239:0] camera_q [$];

    string field_name [12] = '{"pos_x", "pos_y", "pos_z", "front_x", "front_y", "front_z",
                              "right_x", "right_y", "right_z", "up_x", "up_y", "up_z"};

    function automatic longint round_away(longint v, int sh);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : longint'(v);
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp_pos(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned rad_q28(int a);
        return (longint'(a) * 64'd4685083) >> 8;
    endfunction

    function automatic longint unsigned sine_part(int a);
        longint unsigned r, x2, t;
        r = rad_q28(a);
        x2 = (r * r) >> 28;
        t = ONE_Q28 - x2 / 42;
        t = ONE_Q28 - ((x2 * t) >> 28) / 20;
        t = ONE_Q28 - ((x2 * t) >> 28) / 6;
        return (r * t) >> 28;
    endfunction

    function automatic longint unsigned cosine_part(int a);
        longint unsigned r, x2, t;
        r = rad_q28(a);
        x2 = (r * r) >> 28;
        t = ONE_Q28 - x2 / 56;
        t = ONE_Q28 - ((x2 * t) >> 28) / 30;
        t = ONE_Q28 - ((x2 * t) >> 28) / 12;
        return ONE_Q28 - ((x2 * t) >> 28) / 2;
    endfunction

    task automatic angle_trig(input int a, output longint s, output longint c);
        int m;
        bit cneg;
        longint sv, cv;
        m = (a < 0) ? -a : a;
        cneg = 0;
        if (m > HALF_TURN) m = HALF_TURN;
        if (m > 23040) begin
            m = HALF_TURN - m;
            cneg = 1;
        end
        if (m <= 11520) begin
            sv = sine_part(m);
            cv = cosine_part(m);
        end else begin
            sv = cosine_part(23040 - m);
            cv = sine_part(23040 - m);
        end
        s = (a < 0) ? -sv : sv;
        c = cneg ? -cv : cv;
    endtask

    task automatic refresh_basis();
        longint sy, cy, sp, cp;
        angle_trig(yaw, sy, cy);
        angle_trig(pitch, sp, cp);
        basis[0] = 16'(round_away(cy * cp, 42));
        basis[1] = 16'(round_away(sp, 14));
        basis[2] = 16'(round_away(sy * cp, 42));
        basis[3] = 16'(round_away(-sy, 14));
        basis[4] = 16'sd0;
        basis[5] = 16'(round_away(cy, 14));
        basis[6] = 16'(round_away(-(cy * sp), 42));
        basis[7] = 16'(round_away(cp, 14));
        basis[8] = 16'(round_away(-(sy * sp), 42));
    endtask

    task automatic restart_camera();
        for (int i = 0; i < 3; i++) cam_pos[i] = clamp_pos(start_pos[i]);
        yaw = YAW_REST;
        pitch = 0;
        refresh_basis();
    endtask

    task automatic apply_item(input op_t op, input logic [55:0] d);
        int y, p, base;
        logic [2:0] dir;
        longint vel, dlt;
        bit neg;
        logic [239:0] res;
        case (op)
            OP_ROTATE: begin
                y = yaw + int'($signed(d[15:0]));
                p = pitch + int'($signed(d[31:16]));
                if (y >= HALF_TURN) y -= FULL_TURN;
                if (y < -HALF_TURN) y += FULL_TURN;
                if (p > PITCH_LIMIT) p = PITCH_LIMIT;
                if (p < -PITCH_LIMIT) p = -PITCH_LIMIT;
                yaw = y;
                pitch = p;
                refresh_basis();
            end
            OP_MOVE: begin
                dir = d[34:32];
                vel = longint'(speed) * longint'(d[50:35]);
                if (dir <= DIR_DOWN) begin
                    base = int'(dir >> 1) * 3;
                    neg = (dir == DIR_BACKWARD) || (dir == DIR_LEFT) || (dir == DIR_DOWN);
                    for (int i = 0; i < 3; i++) begin
                        dlt = round_away(longint'(basis[base + i]) * vel, 22);
                        cam_pos[i] = clamp_pos(neg ? cam_pos[i] - dlt : cam_pos[i] + dlt);
                    end
                end
            end
            OP_RESTART: restart_camera();
            default: ;
        endcase
        for (int i = 0; i < 3; i++) res[i*32 +: 32] = cam_pos[i][31:0];
        for (int i = 0; i < 9; i++) res[96 + i*16 +: 16] = basis[i];
        camera_q.push_back(res);
    endtask

    always @(posedge aclk) begin
        logic [239:0] want;
        logic [31:0] w, g;
        if (!aresetn) begin
            start_pos = '{0, 0, 0};
            speed = MOVE_SPEED_RESET;
            camera_q.delete();
            fail_count = 0;
            restart_camera();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_START_X:    start_pos[0] = longint'($signed(pwdata));
                    REG_START_Y:    start_pos[1] = longint'($signed(pwdata));
                    REG_START_Z:    start_pos[2] = longint'($signed(pwdata));
                    REG_MOVE_SPEED: speed = pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (camera_q.size() == 0) begin
                    $error("result item with no expectation waiting");
                    fail_count++;
                end else begin
                    want = camera_q.pop_front();
                    for (int i = 0; i < 12; i++) begin
                        if (i < 3) begin
                            w = want[i*32 +: 32];
                            g = m_tdata[i*32 +: 32];
                        end else begin
                            w = {16'd0, want[96 + (i-3)*16 +: 16]};
                            g = {16'd0, m_tdata[96 + (i-3)*16 +: 16]};
                        end
                        if (w !== g) begin
                            $error("%s: expected %h, got %h", field_name[i], w, g);
                            fail_count++;
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) apply_item(op_t'(s_tuser), s_tdata);
        end
        results_pending = camera_q.size();
    end

endmodule

// File: sim/euler_fly_camera_update_tb.sv
`timescale 1ns / 100ps

module euler_fly_camera_update_tb;
    import efcu_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [55:0] s_tdata = '0;   // yaw_offset, pitch_offset, move_direction, time_step
    logic [1:0] s_tuser = '0;    // operation
    logic m_tvalid;
    logic m_tready = 0;
    logic [239:0] m_tdata;       // pos_x..z, front_x..z, right_x..z, up_x..z
    logic psel = 0, penable = 0, pwrite = 0, pready;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;

    int fail_count, results_pending;
    int cycles = 0;
    bit steady = 0;
    bit hold_req = 0;

    euler_fly_camera_update u_dut (.*);

    efcu_checker u_chk (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (hold_req) begin
            m_tready = 0;
            repeat (600) @(negedge aclk);
            hold_req = 0;
        end else if (!aresetn) begin
            m_tready = 0;
        end else begin
            m_tready = steady || ($urandom_range(99) >= 8);
        end
    end

    task automatic send_item(input op_t op, input logic [15:0] yaw_ofs,
                             input logic [15:0] pitch_ofs, input logic [2:0] dir,
                             input logic [15:0] tstep);
        @(negedge aclk);
        if (!steady && $urandom_range(99) < 8) begin
            s_tvalid = 0;
            repeat ($urandom_range(4)) @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser = op;
        s_tdata = {5'd0, tstep, dir, pitch_ofs, yaw_ofs};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic rotate_by(input int yv, input int pv);
        send_item(OP_ROTATE, 16'(yv), 16'(pv), 3'($urandom), 16'($urandom));
    endtask

    task automatic move_by(input logic [2:0] dir, input logic [15:0] tstep);
        send_item(OP_MOVE, 16'($urandom), 16'($urandom), dir, tstep);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 0;
        while (results_pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge aclk);
        penable = 1;
        @(negedge aclk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic random_item();
        int k;
        logic [15:0] yv, pv;
        k = $urandom_range(99);
        yv = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($signed($urandom_range(8000)) - 4000);
        pv = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($signed($urandom_range(8000)) - 4000);
        if (k < 40) send_item(OP_ROTATE, yv, pv, 3'($urandom), 16'($urandom));
        else if (k < 88) send_item(OP_MOVE, yv, pv,
                                   ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(5)),
                                   16'($urandom));
        else if (k < 95) send_item(OP_RESTART, yv, pv, 3'($urandom), 16'($urandom));
        else send_item(OP_NONE, yv, pv, 3'($urandom), 16'($urandom));
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn = 1;

        // directed
        rotate_by(0, 0);
        rotate_by(32767, 32767);
        rotate_by(-32768, -32768);
        rotate_by(-32768, 0);
        rotate_by(23040, 5000);
        rotate_by(23040, -10000);
        for (int d = 0; d < 8; d++) move_by(3'(d), 16'hFFFF);
        move_by(DIR_FORWARD, 16'd0);
        move_by(DIR_UP, 16'd1);
        send_item(OP_NONE, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF);
        send_item(OP_RESTART, 16'h7FFF, 16'h8000, 3'd7, 16'hFFFF);
        drain();

        reg_write(REG_START_X, 32'h7FFF_F000);
        reg_write(REG_START_Y, 32'h8000_0000);
        reg_write(REG_START_Z, 32'h7FFF_FFFF);
        reg_write(REG_MOVE_SPEED, 32'h0000_FFFF);
        send_item(OP_RESTART, 16'd0, 16'd0, 3'd0, 16'd0);
        for (int i = 0; i < 4; i++) begin
            move_by(DIR_RIGHT, 16'hFFFF);
            move_by(DIR_BACKWARD, 16'hFFFF);
        end
        steady = 1;
        for (int i = 0; i < 200; i++) random_item();
        steady = 0;
        hold_req = 1;
        for (int i = 0; i < 200; i++) random_item();
        drain();

        reg_write(REG_MOVE_SPEED, 32'd0);
        reg_write(REG_START_X, 32'd0);
        reg_write(REG_START_Y, 32'd0);
        reg_write(REG_START_Z, 32'd0);
        for (int i = 0; i < 150; i++) random_item();
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            reg_write(REG_START_X, $urandom);
            reg_write(REG_START_Y, $urandom);
            reg_write(REG_START_Z, $urandom);
            reg_write(REG_MOVE_SPEED, $urandom);
            for (int i = 0; i < 180; i++) random_item();
            drain();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
